// ----- src/gmds_pkg.sv -----
// gmds_pkg: shared sizes, codes and types of the grid maze depth-first solver
// used by gmds_stack and grid_maze_dfs_solver; depends on nothing else
package gmds_pkg;

  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int DEPTH_W = $clog2(CELLS + 1);
  localparam int CFG_W   = 6;
  localparam int CMP_W   = 10;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_SOLVE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // cell codes
  localparam logic [2:0] CELL_OPEN    = 3'd0;
  localparam logic [2:0] CELL_WALL    = 3'd1;
  localparam logic [2:0] CELL_START   = 3'd2;
  localparam logic [2:0] CELL_END     = 3'd3;
  localparam logic [2:0] CELL_PATH    = 3'd4;
  localparam logic [2:0] CELL_VISITED = 3'd5;

  // search directions, in the order they are tried
  localparam logic [2:0] DIR_LEFT  = 3'd0;
  localparam logic [2:0] DIR_DOWN  = 3'd1;
  localparam logic [2:0] DIR_RIGHT = 3'd2;
  localparam logic [2:0] DIR_UP    = 3'd3;
  localparam logic [2:0] DIR_DONE  = 3'd4;

  // stacked frame; tried holds the number of directions tried minus one
  typedef struct packed {
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    logic [1:0]       tried;
  } frame_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    frame_t            wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } stk_req_t;

endpackage

// ----- src/gmds_stack.sv -----
// gmds_stack: frame store of the search stack, one write and one read per cycle
// read data registered; depends on gmds_pkg
module gmds_stack (
  input  logic              clk,
  input  gmds_pkg::stk_req_t req,
  output gmds_pkg::frame_t   q
);
  import gmds_pkg::*;

  frame_t mem [CELLS];
  frame_t q_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      q_r <= mem[req.raddr];
    end
  end

  assign q = q_r;

endmodule

// ----- src/grid_maze_dfs_solver.sv -----
// grid_maze_dfs_solver: load, read and depth-first solve over a cell grid memory
// load, read and unknown words give their result registered, in the cycle after acceptance,
// one word per cycle while no solve runs and the output is not stalled; a solve probes the
// start cell, then each neighbor by grid read then decide, and each backtrack by stack read then pop
// synchronous active-low reset clears control, start position and stack depth and
// sets width and height to 32; grid and stack memories are not cleared
module grid_maze_dfs_solver (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [gmds_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [15:0]              in_tdata,   // row[4:0], col[9:5], cell_in[11:10], zero
  input  logic [1:0]               in_tuser,   // kind[1:0]
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [7:0]               out_tdata   // cell_out[2:0], solved[3], zero
);
  import gmds_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_TRY  = 4'b0010,
    ST_STEP = 4'b0100,
    ST_POP  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]   width_r, width_nxt, height_r, height_nxt;
  logic [ROW_W-1:0]   start_row_r, start_row_nxt;
  logic [COL_W-1:0]   start_col_r, start_col_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [ROW_W-1:0]   top_r_r, top_r_nxt, cand_r_r, cand_r_nxt;
  logic [COL_W-1:0]   top_c_r, top_c_nxt, cand_c_r, cand_c_nxt;
  logic [2:0]         top_dir_r, top_dir_nxt;
  logic               cand_ok_r, cand_ok_nxt, first_r, first_nxt;
  logic               out_valid_r, out_valid_nxt, solved_r, solved_nxt;
  logic               rd_is_r, rd_is_nxt;

  logic [4:0] in_row, in_col;
  logic [1:0] in_cell, in_kind;
  logic       in_fire;

  logic [CFG_W-1:0]   lim_r, lim_c;
  logic [DEPTH_W-1:0] depth_m1, depth_m2;

  logic              g_we, g_re;
  logic [ADDR_W-1:0] g_waddr, g_raddr;
  logic [2:0]        g_wdata, grid_q;
  logic [2:0]        grid [CELLS];

  stk_req_t stk_req;
  frame_t   stk_q;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    cell_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c));
  endfunction

  assign in_row  = in_tdata[4:0];
  assign in_col  = in_tdata[9:5];
  assign in_cell = in_tdata[11:10];
  assign in_kind = in_tuser;

  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, solved_r, (rd_is_r ? grid_q : CELL_OPEN)};

  assign lim_r = (int'(height_r) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : height_r;
  assign lim_c = (int'(width_r) > MAX_COLS) ? CFG_W'(MAX_COLS) : width_r;
  assign depth_m1 = depth_r - DEPTH_W'(1);
  assign depth_m2 = depth_r - DEPTH_W'(2);

  always_comb begin
    state_nxt     = state_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    start_row_nxt = start_row_r;
    start_col_nxt = start_col_r;
    depth_nxt     = depth_r;
    top_r_nxt     = top_r_r;
    top_c_nxt     = top_c_r;
    top_dir_nxt   = top_dir_r;
    cand_r_nxt    = cand_r_r;
    cand_c_nxt    = cand_c_r;
    cand_ok_nxt   = cand_ok_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r;
    solved_nxt    = solved_r;
    rd_is_nxt     = rd_is_r;
    g_we          = 1'b0;
    g_waddr       = cell_addr(top_r_r, top_c_r);
    g_wdata       = CELL_VISITED;
    g_re          = 1'b0;
    g_raddr       = cell_addr(cand_r_r, cand_c_r);
    stk_req.we    = 1'b0;
    stk_req.waddr = depth_m1[ADDR_W-1:0];
    stk_req.wdata = '{r: top_r_r, c: top_c_r, tried: 2'(top_dir_r - 3'd1)};
    stk_req.re    = 1'b0;
    stk_req.raddr = depth_m2[ADDR_W-1:0];

    if (cfg_we) begin
      if (cfg_index == REG_WIDTH) begin
        width_nxt = cfg_wdata;
      end else begin
        height_nxt = cfg_wdata;
      end
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          solved_nxt = 1'b0;
          rd_is_nxt  = 1'b0;
          unique case (in_kind)
            KIND_LOAD: begin
              out_valid_nxt = 1'b1;
              if (int'(in_row) < MAX_ROWS && int'(in_col) < MAX_COLS) begin
                g_we    = 1'b1;
                g_waddr = cell_addr(ROW_W'(in_row), COL_W'(in_col));
                g_wdata = {1'b0, in_cell};
                if ({1'b0, in_cell} == CELL_START) begin
                  start_row_nxt = ROW_W'(in_row);
                  start_col_nxt = COL_W'(in_col);
                end
              end
            end
            KIND_SOLVE: begin
              cand_r_nxt  = ROW_W'(in_row);
              cand_c_nxt  = COL_W'(in_col);
              cand_ok_nxt = (CMP_W'(in_row) < CMP_W'(lim_r)) &&
                            (CMP_W'(in_col) < CMP_W'(lim_c));
              first_nxt   = 1'b1;
              depth_nxt   = '0;
              g_re        = 1'b1;
              g_raddr     = cell_addr(ROW_W'(in_row), COL_W'(in_col));
              state_nxt   = ST_TRY;
            end
            KIND_READ: begin
              out_valid_nxt = 1'b1;
              if (int'(in_row) < MAX_ROWS && int'(in_col) < MAX_COLS) begin
                rd_is_nxt = 1'b1;
                g_re      = 1'b1;
                g_raddr   = cell_addr(ROW_W'(in_row), COL_W'(in_col));
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_TRY: begin
        if (!cand_ok_r || grid_q == CELL_WALL || grid_q == CELL_PATH ||
            grid_q == CELL_VISITED || depth_r == DEPTH_W'(CELLS)) begin
          // blocked neighbor; a blocked start fails at once
          if (first_r) begin
            out_valid_nxt = 1'b1;
            solved_nxt    = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_STEP;
          end
        end else if (grid_q == CELL_END) begin
          g_we          = 1'b1;
          g_waddr       = cell_addr(start_row_r, start_col_r);
          g_wdata       = CELL_START;
          depth_nxt     = '0;
          out_valid_nxt = 1'b1;
          solved_nxt    = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          // enter: mark path, spill old top to the stack memory
          g_we        = 1'b1;
          g_waddr     = cell_addr(cand_r_r, cand_c_r);
          g_wdata     = CELL_PATH;
          stk_req.we  = (depth_r != '0);
          depth_nxt   = depth_r + DEPTH_W'(1);
          top_r_nxt   = cand_r_r;
          top_c_nxt   = cand_c_r;
          top_dir_nxt = DIR_LEFT;
          state_nxt   = ST_STEP;
        end
      end
      ST_STEP: begin
        if (top_dir_r == DIR_DONE) begin
          g_we      = 1'b1;
          depth_nxt = depth_m1;
          if (depth_r == DEPTH_W'(1)) begin
            out_valid_nxt = 1'b1;
            solved_nxt    = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            stk_req.re = 1'b1;
            state_nxt  = ST_POP;
          end
        end else begin
          cand_r_nxt = top_r_r;
          cand_c_nxt = top_c_r;
          unique case (top_dir_r)
            DIR_LEFT: begin
              cand_c_nxt  = top_c_r - COL_W'(1);
              cand_ok_nxt = (top_c_r != '0);
            end
            DIR_DOWN: begin
              cand_r_nxt  = top_r_r + ROW_W'(1);
              cand_ok_nxt = (CMP_W'(top_r_r) + CMP_W'(1)) < CMP_W'(lim_r);
            end
            DIR_RIGHT: begin
              cand_c_nxt  = top_c_r + COL_W'(1);
              cand_ok_nxt = (CMP_W'(top_c_r) + CMP_W'(1)) < CMP_W'(lim_c);
            end
            default: begin
              cand_r_nxt  = top_r_r - ROW_W'(1);
              cand_ok_nxt = (top_r_r != '0);
            end
          endcase
          g_re        = 1'b1;
          g_raddr     = cell_addr(cand_r_nxt, cand_c_nxt);
          first_nxt   = 1'b0;
          top_dir_nxt = top_dir_r + 3'd1;
          state_nxt   = ST_TRY;
        end
      end
      ST_POP: begin
        top_r_nxt   = stk_q.r;
        top_c_nxt   = stk_q.c;
        top_dir_nxt = {1'b0, stk_q.tried} + 3'd1;
        state_nxt   = ST_STEP;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      width_r     <= CFG_W'(32);
      height_r    <= CFG_W'(32);
      start_row_r <= '0;
      start_col_r <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
      rd_is_r     <= 1'b0;
      solved_r    <= 1'b0;
      first_r     <= 1'b0;
      cand_ok_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      start_row_r <= start_row_nxt;
      start_col_r <= start_col_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
      rd_is_r     <= rd_is_nxt;
      solved_r    <= solved_nxt;
      first_r     <= first_nxt;
      cand_ok_r   <= cand_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r_r   <= top_r_nxt;
    top_c_r   <= top_c_nxt;
    top_dir_r <= top_dir_nxt;
    cand_r_r  <= cand_r_nxt;
    cand_c_r  <= cand_c_nxt;
  end

  // grid memory, read data held until the next read
  always_ff @(posedge clk) begin
    if (g_we) begin
      grid[g_waddr] <= g_wdata;
    end
    if (g_re) begin
      grid_q <= grid[g_raddr];
    end
  end

  gmds_stack u_stack (
    .clk (clk),
    .req (stk_req),
    .q   (stk_q)
  );

`ifndef ASSERT_OFF
  a_no_result_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !out_valid_r)
    else $error("result word pending during search");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(CELLS))
    else $error("stack depth beyond grid size");

  a_solve_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_kind == KIND_SOLVE) |=> (state_r == ST_TRY))
    else $error("solve word did not start a probe");

  a_pop_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |-> ($past(state_r) == ST_STEP && depth_r != '0))
    else $error("stack pop out of sequence");
`endif

endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking bench for grid_maze_dfs_solver, loads random mazes, solves and reads back
// a tracker class keeps its own grid and search stack and checks every result word in order
// depends on gmds_pkg and the grid_maze_dfs_solver rtl
module tb_top;
  import gmds_pkg::*;

  localparam logic [1:0] KIND_NONE   = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         ITEM_GOAL   = 1350;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  logic                cfg_index  = REG_WIDTH;
  logic [CFG_W-1:0]    cfg_wdata  = '0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [15:0]         in_tdata   = '0;  // row[4:0], col[9:5], cell_in[11:10], zero
  logic [1:0]          in_tuser   = '0;  // kind[1:0]
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [7:0]          out_tdata;        // cell_out[2:0], solved[3], zero

  int src_idle_pct  = 17;
  int sink_idle_pct = 81;
  int items_sent    = 0;
  int cycle_count   = 0;

  class maze_tracker;
    typedef enum int {STEP_BLOCKED, STEP_END, STEP_ENTERED} step_t;
    typedef struct packed {
      logic       solved;
      logic [2:0] cell_out;
    } reply_t;

    logic [2:0] cells [CELLS];
    bit         known [CELLS];
    int         stk_r [CELLS];
    int         stk_c [CELLS];
    logic [2:0] stk_dir [CELLS];
    int         depth;
    int         start_r;
    int         start_c;
    int         width;
    int         height;
    reply_t     replies [$];
    int         fails;

    function new();
      foreach (cells[i]) begin
        cells[i] = CELL_OPEN;
        known[i] = 1'b0;
      end
      depth   = 0;
      start_r = 0;
      start_c = 0;
      width   = 32;
      height  = 32;
      fails   = 0;
    endfunction

    function void set_size(int w, int h);
      width  = w & 63;
      height = h & 63;
    endfunction

    function int pending();
      return replies.size();
    endfunction

    function step_t enter_cell(int r, int c);
      int lim_r;
      int lim_c;
      int idx;
      lim_r = (height < MAX_ROWS) ? height : MAX_ROWS;
      lim_c = (width < MAX_COLS) ? width : MAX_COLS;
      if (r < 0 || r >= lim_r || c < 0 || c >= lim_c) return STEP_BLOCKED;
      idx = r * MAX_COLS + c;
      if (cells[idx] == CELL_WALL || cells[idx] == CELL_PATH || cells[idx] == CELL_VISITED)
        return STEP_BLOCKED;
      if (cells[idx] == CELL_END) begin
        // success puts the start mark back where the last start load was
        cells[start_r * MAX_COLS + start_c] = CELL_START;
        known[start_r * MAX_COLS + start_c] = 1'b1;
        return STEP_END;
      end
      if (depth >= CELLS) return STEP_BLOCKED;
      cells[idx]     = CELL_PATH;
      stk_r[depth]   = r;
      stk_c[depth]   = c;
      stk_dir[depth] = DIR_LEFT;
      depth++;
      return STEP_ENTERED;
    endfunction

    function logic dfs_solve(int r0, int c0);
      int top;
      int nr;
      int nc;
      depth = 0;
      if (enter_cell(r0, c0) == STEP_END) return 1'b1;
      while (depth > 0) begin
        top = depth - 1;
        nr  = stk_r[top];
        nc  = stk_c[top];
        if (stk_dir[top] >= DIR_DONE) begin
          cells[nr * MAX_COLS + nc] = CELL_VISITED;
          depth--;
          continue;
        end
        case (stk_dir[top])
          DIR_LEFT:  nc--;
          DIR_DOWN:  nr++;
          DIR_RIGHT: nc++;
          default:   nr--;
        endcase
        stk_dir[top]++;
        if (enter_cell(nr, nc) == STEP_END) begin
          depth = 0;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_word(logic [1:0] kind, logic [4:0] row, logic [4:0] col,
                            logic [1:0] code);
      reply_t rep;
      int     idx;
      rep = '0;
      idx = int'(row) * MAX_COLS + int'(col);
      case (kind)
        KIND_LOAD: begin
          cells[idx] = {1'b0, code};
          known[idx] = 1'b1;
          if ({1'b0, code} == CELL_START) begin
            start_r = int'(row);
            start_c = int'(col);
          end
        end
        KIND_SOLVE: rep.solved = dfs_solve(int'(row), int'(col));
        KIND_READ:  rep.cell_out = cells[idx];
        default: ;
      endcase
      replies.push_back(rep);
    endfunction

    function void check_reply(logic [7:0] word);
      reply_t want;
      if (replies.size() == 0) begin
        $display("%0t: result word %h with nothing expected", $time, word);
        fails++;
        return;
      end
      want = replies.pop_front();
      if (word[2:0] !== want.cell_out) begin
        $display("%0t: cell_out expected %0d actual %0d", $time, want.cell_out, word[2:0]);
        fails++;
      end
      if (word[3] !== want.solved) begin
        $display("%0t: solved expected %0d actual %0d", $time, want.solved, word[3]);
        fails++;
      end
    endfunction
  endclass

  maze_tracker tracker;

  grid_maze_dfs_solver DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[grid_maze_dfs_solver] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) tracker.check_reply(out_tdata);
    out_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  task automatic send_word(logic [1:0] kind, int row, int col, int code);
    logic [4:0] r;
    logic [4:0] c;
    logic [1:0] v;
    r = row[4:0];
    c = col[4:0];
    v = code[1:0];
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, v, c, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_word(kind, r, c, v);
    items_sent++;
  endtask

  // stop feeding and let every outstanding word come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic set_size(int w, int h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_wdata <= w[CFG_W-1:0];
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_wdata <= h[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_size(w, h);
    @(posedge clk);
  endtask

  // reads only cells that hold a loaded value
  task automatic read_cells(int n, int eh, int ew);
    int r;
    int c;
    repeat (n) begin
      if (eh * ew > 0 && $urandom_range(0, 99) < 70) begin
        r = $urandom_range(0, eh - 1);
        c = $urandom_range(0, ew - 1);
        send_word(KIND_READ, r, c, $urandom_range(0, 3));
      end else begin
        r = $urandom_range(0, 31);
        c = $urandom_range(0, 31);
        if (tracker.known[r * MAX_COLS + c]) send_word(KIND_READ, r, c, $urandom_range(0, 3));
      end
    end
  endtask

  task automatic run_maze(int maze_num);
    int w;
    int h;
    int ew;
    int eh;
    int sr;
    int sc;
    int er;
    int ec;
    int code;
    bit has_end;
    case ((maze_num < 3) ? maze_num : $urandom_range(3, 12))
      0: begin w = 63; h = 1; end
      1: begin w = 2; h = 63; end
      2: begin w = 0; h = $urandom_range(1, 8); end
      3: begin w = $urandom_range(32, 63); h = $urandom_range(0, 2); end
      4: begin w = $urandom_range(0, 2); h = $urandom_range(32, 63); end
      5: begin w = $urandom_range(1, 8); h = 0; end
      default: begin w = $urandom_range(1, 8); h = $urandom_range(1, 8); end
    endcase
    drain();
    set_size(w, h);
    ew = (w < MAX_COLS) ? w : MAX_COLS;
    eh = (h < MAX_ROWS) ? h : MAX_ROWS;
    sr = 0;
    sc = 0;
    if (ew * eh > 0) begin
      sr = $urandom_range(0, eh - 1);
      sc = $urandom_range(0, ew - 1);
      er = $urandom_range(0, eh - 1);
      ec = $urandom_range(0, ew - 1);
      has_end = ($urandom_range(0, 99) < 85);
      for (int r = 0; r < eh; r++) begin
        for (int c = 0; c < ew; c++) begin
          if ($urandom_range(0, 99) < 6)
            send_word(KIND_LOAD, $urandom_range(0, 31), $urandom_range(0, 31),
                      $urandom_range(0, 3));
          if (has_end && r == er && c == ec) code = CELL_END;
          else if ($urandom_range(0, 99) < 5) code = $urandom_range(0, 3);
          else if ($urandom_range(0, 99) < 30) code = CELL_WALL;
          else code = CELL_OPEN;
          send_word(KIND_LOAD, r, c, code);
        end
      end
      // start load last so it sets the start position
      send_word(KIND_LOAD, sr, sc, CELL_START);
    end
    read_cells($urandom_range(0, 2), eh, ew);
    if (ew * eh > 0 && $urandom_range(0, 99) < 80) send_word(KIND_SOLVE, sr, sc, 0);
    else send_word(KIND_SOLVE, $urandom_range(0, 31), $urandom_range(0, 31),
                   $urandom_range(0, 3));
    if ($urandom_range(0, 99) < 10)
      send_word(KIND_NONE, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 3));
    read_cells($urandom_range(3, 8), eh, ew);
    if (ew * eh > 0 && $urandom_range(0, 99) < 25) begin
      send_word(KIND_SOLVE, $urandom_range(0, eh - 1), $urandom_range(0, ew - 1), 0);
      read_cells($urandom_range(1, 4), eh, ew);
    end
  endtask

  initial begin
    int maze_num;
    tracker = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // small 3x2 maze: start top left, end top right, one wall below the middle
    set_size(3, 2);
    send_word(KIND_LOAD, 0, 0, CELL_START);
    send_word(KIND_LOAD, 0, 1, CELL_OPEN);
    send_word(KIND_LOAD, 0, 2, CELL_END);
    send_word(KIND_LOAD, 1, 0, CELL_OPEN);
    send_word(KIND_LOAD, 1, 1, CELL_WALL);
    send_word(KIND_LOAD, 1, 2, CELL_OPEN);
    send_word(KIND_LOAD, 31, 31, CELL_WALL);
    send_word(KIND_READ, 31, 31, 0);
    send_word(KIND_NONE, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 3));
    send_word(KIND_SOLVE, 0, 0, 0);
    send_word(KIND_READ, 1, 0, 0);
    send_word(KIND_READ, 0, 1, 0);
    send_word(KIND_READ, 0, 0, 0);
    send_word(KIND_SOLVE, 1, 1, 0);   // start on a wall
    send_word(KIND_SOLVE, 0, 2, 0);   // start on the end
    send_word(KIND_SOLVE, 31, 31, 0); // start outside the size
    send_word(KIND_SOLVE, 0, 1, 0);   // start on a path cell
    send_word(KIND_READ, 1, 2, 3);
    drain();
    set_size(0, 2);
    send_word(KIND_SOLVE, 0, 0, 0);   // no column in use
    send_word(KIND_READ, 0, 0, 0);

    maze_num = 0;
    while (items_sent < ITEM_GOAL) begin
      if (items_sent < ITEM_GOAL / 3) begin
        src_idle_pct  = 17;
        sink_idle_pct = 81;
      end else if (items_sent < 2 * ITEM_GOAL / 3) begin
        src_idle_pct  = 81;
        sink_idle_pct = 17;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      run_maze(maze_num);
      maze_num++;
    end

    drain();
    repeat (20) @(posedge clk);
    if (tracker.fails == 0 && tracker.pending() == 0) begin
      $display("[grid_maze_dfs_solver] OK");
    end else begin
      $display("[grid_maze_dfs_solver] ERROR");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
src/gmds_pkg.sv
src/gmds_stack.sv
src/grid_maze_dfs_solver.sv
tb/tb_top.sv
